// File: rtl/stable_descending_merge_sorter_macros.svh
// Assertion macros used by the sorter checker.
`ifndef STABLE_DESCENDING_MERGE_SORTER_MACROS_SVH
`define STABLE_DESCENDING_MERGE_SORTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter check failed");

`endif

// File: rtl/sms_pkg.sv
// Types shared by the merge sorter modules.
package sms_pkg;

    localparam int KEY_W = 24;
    localparam int TAG_W = 16;

    typedef struct packed {
        logic [KEY_W-1:0] freq_key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } sms_in_t;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [TAG_W-1:0] out_tag;
        logic             out_last;
        logic             overflow;
    } sms_out_t;

    // One stored record: key above tag.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } sms_rec_t;

endpackage

// File: rtl/sms_bank.sv
// Record memory: one write port, two registered read ports.
module sms_bank
    import sms_pkg::*;
#(
    parameter int AW = 6
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  sms_rec_t      wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output sms_rec_t      rdata_a,
    output sms_rec_t      rdata_b
);

    localparam int DEPTH = 1 << AW;

    sms_rec_t mem [DEPTH];
    sms_rec_t rdata_a_reg;
    sms_rec_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: rtl/sms_pick.sv
// Merge step: picks the next record from the two run heads.
module sms_pick
    import sms_pkg::*;
#(
    parameter int CW = 7
)
(
    input  sms_rec_t      left,
    input  sms_rec_t      right,
    input  logic [CW-1:0] a,
    input  logic [CW-1:0] mid,
    input  logic [CW-1:0] b,
    input  logic [CW-1:0] hi,
    output logic          take_left,
    output sms_rec_t      pick
);

    // Ties go left, which keeps the sort stable.
    always_comb
    begin
        priority if (a >= mid)
        begin
            take_left = 1'b0;
        end
        else if (b >= hi)
        begin
            take_left = 1'b1;
        end
        else
        begin
            take_left = (left.key >= right.key);
        end
        pick = take_left ? left : right;
    end

endmodule

// File: rtl/stable_descending_merge_sorter.sv
// Top level of the stable descending merge sorter.
// Usage: drive item and pulse start; an item is taken on a clock edge with start high
// and busy low, one per cycle while loading. Records without last are stored and
// give no result. A record with last closes the set (if the store already holds
// MAX_RECORDS records, that record, like any extra record before it, is dropped and
// overflow is set).
// The block then raises busy, sorts the n held records with bottom-up merge
// passes between two record banks, and emits n results, one per cycle, each marked by
// strobe for exactly one cycle; out_last flags the final one and overflow is the same
// on all of them. busy falls right after the last result.
// Sorting: one merge unit writes one record per cycle; each pass opens with a
// priming state and there are ceil(log2 n) passes; output opens with a priming state of its own.
// Reset clears the record count, the overflow flag and the sequencer; bank contents
// are not cleared. The receiver cannot stall, so results are never held back.
module stable_descending_merge_sorter
    import sms_pkg::*;
#(
    parameter int MAX_RECORDS = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  sms_in_t  item,
    output logic     strobe,
    output sms_out_t result
);

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRIME = 3'd1;
    localparam logic [2:0] ST_MERGE = 3'd2;
    localparam logic [2:0] ST_OPRIME = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          src_reg, src_next;
    logic [SW-1:0] width_reg, width_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] k_reg, k_next;

    logic [AW-1:0] rd_a, rd_b, wr_addr;
    logic          we0, we1;
    sms_rec_t      wr_data;
    sms_rec_t      q0a, q0b, q1a, q1b, qa, qb;

    logic          take_left;
    sms_rec_t      pick;

    logic [SW-1:0] n_ext, base, mid_sum, hi_sum, run_mid, run_hi, width2;
    logic [CW-1:0] count_after, k_inc, a_adv, b_adv;

    sms_bank #(.AW(AW)) u_bank0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (q0a),
        .rdata_b (q0b)
    );

    sms_bank #(.AW(AW)) u_bank1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (q1a),
        .rdata_b (q1b)
    );

    assign qa = src_reg ? q1a : q0a;
    assign qb = src_reg ? q1b : q0b;

    sms_pick #(.CW(CW)) u_pick (
        .left      (qa),
        .right     (qb),
        .a         (a_reg),
        .mid       (mid_reg),
        .b         (b_reg),
        .hi        (hi_reg),
        .take_left (take_left),
        .pick      (pick)
    );

    // Bounds of the next run: starts at 0 on a new pass, else where this run ends.
    always_comb
    begin
        n_ext   = SW'(count_reg);
        base    = (state_reg == ST_PRIME) ? '0 : SW'(hi_reg);
        mid_sum = base + width_reg;
        hi_sum  = base + (width_reg << 1);
        run_mid = (mid_sum > n_ext) ? n_ext : mid_sum;
        run_hi  = (hi_sum > n_ext) ? n_ext : hi_sum;
        width2  = width_reg << 1;
        k_inc   = k_reg + 1'b1;
        a_adv   = a_reg + CW'(take_left);
        b_adv   = b_reg + CW'(!take_left);
        count_after = (count_reg < MAX_CNT) ? (count_reg + 1'b1) : count_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        src_next   = src_reg;
        width_next = width_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        rd_a       = a_reg[AW-1:0];
        rd_b       = b_reg[AW-1:0];
        we0        = 1'b0;
        we1        = 1'b0;
        wr_addr    = k_reg[AW-1:0];
        wr_data    = pick;
        strobe     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        we0     = 1'b1;
                        wr_addr = count_reg[AW-1:0];
                        wr_data = '{key: item.freq_key, tag: item.tag};
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = count_after;
                    if (item.last)
                    begin
                        width_next = SW'(1);
                        src_next   = 1'b0;
                        state_next = (count_after >= CW'(2)) ? ST_PRIME : ST_OPRIME;
                    end
                end
            end

            ST_PRIME:
            begin
                a_next     = '0;
                b_next     = CW'(run_mid);
                mid_next   = CW'(run_mid);
                hi_next    = CW'(run_hi);
                k_next     = '0;
                rd_a       = '0;
                rd_b       = run_mid[AW-1:0];
                state_next = ST_MERGE;
            end

            ST_MERGE:
            begin
                we0    = src_reg;
                we1    = !src_reg;
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    if (hi_reg == count_reg)
                    begin
                        // pass done: results now sit in the other bank
                        width_next = width2;
                        src_next   = !src_reg;
                        state_next = (width2 >= n_ext) ? ST_OPRIME : ST_PRIME;
                    end
                    else
                    begin
                        a_next   = hi_reg;
                        b_next   = CW'(run_mid);
                        mid_next = CW'(run_mid);
                        hi_next  = CW'(run_hi);
                        rd_a     = hi_reg[AW-1:0];
                        rd_b     = run_mid[AW-1:0];
                    end
                end
                else
                begin
                    a_next = a_adv;
                    b_next = b_adv;
                    rd_a   = a_adv[AW-1:0];
                    rd_b   = b_adv[AW-1:0];
                end
            end

            ST_OPRIME:
            begin
                rd_a       = '0;
                k_next     = '0;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                strobe = 1'b1;
                rd_a   = k_inc[AW-1:0];
                k_next = k_inc;
                if (k_inc == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            src_reg   <= 1'b0;
            width_reg <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            src_reg   <= src_next;
            width_reg <= width_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            k_reg     <= k_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        result.out_key  = qa.key;
        result.out_tag  = qa.tag;
        result.out_last = (k_inc == count_reg);
        result.overflow = ovf_reg;
    end

endmodule

// File: rtl/sms_checker.sv
// Port-level checker for the merge sorter, bound to the top level.
`include "stable_descending_merge_sorter_macros.svh"

module sms_checker
    import sms_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input sms_in_t  item,
    input logic     strobe,
    input sms_out_t result
);

    // results only come out during the busy phase
    `SMS_ASSERT_NOW(a_strobe_busy, strobe, busy)
    // an item without last leaves the block ready
    `SMS_ASSERT_NEXT(a_load_stays_idle, start && !busy && !item.last, !busy)
    // closing a set starts the sort, never a result in the next cycle
    `SMS_ASSERT_NEXT(a_last_starts_sort, start && !busy && item.last, busy && !strobe)
    // the final result ends the busy phase
    `SMS_ASSERT_NEXT(a_final_frees, strobe && result.out_last, !busy && !strobe)

endmodule

bind stable_descending_merge_sorter sms_checker u_sms_checker (.*);
